// File: src/lz3d_pkg.sv
// ---------------------------------------------------------------------------
// lz3d_pkg
// Shared types, codes and helper functions of the three-stream LZ decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package lz3d_pkg;

  // Bytes carried by one result beat.
  localparam int unsigned OutputLanes = 8;
  // History window.
  localparam int unsigned HistAddrW   = 12;
  localparam int unsigned HistDepth   = 1 << HistAddrW;
  // Length coding of a link halfword.
  localparam int unsigned ExtLenBias  = 18;
  localparam int unsigned ShortBias   = 2;
  // Copy length fits 9 bits (up to 255 + 18).
  localparam int unsigned LenW        = 9;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_FLAG  = 2'd1,
    OP_CHUNK = 2'd2,
    OP_LINK  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_KIND   = 2'd1,
    ST_BEFORE = 2'd2,
    ST_PAST   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    NEED_FLAG  = 2'd0,
    NEED_CHUNK = 2'd1,
    NEED_LINK  = 2'd2,
    NEED_DONE  = 2'd3
  } need_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FLAG,
    PH_LIT,
    PH_LINK,
    PH_EXT
  } phase_t;

  typedef enum logic {
    ENG_IDLE,
    ENG_COPY
  } eng_t;

  // Phase after a flag has been used or a fresh flag word has arrived.
  function automatic phase_t choose_next(logic [31:0] pc, logic [31:0] exp_len,
                                         logic [5:0] left, logic [31:0] shift);
    phase_t ph;
    if (pc >= exp_len) begin
      ph = PH_IDLE;
    end else if (left == 6'd0) begin
      ph = PH_FLAG;
    end else if (shift[31]) begin
      ph = PH_LIT;
    end else begin
      ph = PH_LINK;
    end
    return ph;
  endfunction

  // Item kind requested while in a given phase.
  function automatic need_t need_code(phase_t ph);
    need_t n;
    unique case (ph)
      PH_FLAG: n = NEED_FLAG;
      PH_LIT:  n = NEED_CHUNK;
      PH_EXT:  n = NEED_CHUNK;
      PH_LINK: n = NEED_LINK;
      default: n = NEED_DONE;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// File: src/lz_three_stream_decoder_core.sv
// ---------------------------------------------------------------------------
// lz_three_stream_decoder_core
// Decodes a flag / link / chunk split LZ stream into groups of up to eight
// bytes, keeping a 4096-byte history in a synchronous memory.
// ---------------------------------------------------------------------------
// Channel  | Direction | Handshake          | Beat payload
// in_      | input     | in_valid/in_stall  | opcode, frame length, flag, chunk, link
// out_     | output    | out_valid/out_stall| eight bytes, count, last, need, status
//
// Items that decode at most one byte give one beat.
// A copy of L bytes runs one byte per cycle through the history memory
// port, pausing while a stalled output holds a beat, and gives ceil(L/8) beats.
// Reset is synchronous and active low; the history is not cleared.
// A stalled output holds the beat and pauses the copy engine and the input.
// ---------------------------------------------------------------------------
`default_nettype none

module lz_three_stream_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_frame_length,
  input  wire logic [31:0] in_flag_word,
  input  wire logic [7:0]  in_chunk_byte,
  input  wire logic [15:0] in_link_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte_0,
  output logic [7:0]       out_byte_1,
  output logic [7:0]       out_byte_2,
  output logic [7:0]       out_byte_3,
  output logic [7:0]       out_byte_4,
  output logic [7:0]       out_byte_5,
  output logic [7:0]       out_byte_6,
  output logic [7:0]       out_byte_7,
  output logic [3:0]       out_byte_count,
  output logic             out_last_of_run,
  output logic [1:0]       out_next_need,
  output logic [1:0]       out_status
);

  localparam int unsigned AW = lz3d_pkg::HistAddrW;
  localparam int unsigned LW = lz3d_pkg::LenW;
  localparam int unsigned NL = lz3d_pkg::OutputLanes;

  // History memory and its registered read port.
  logic [7:0]    hist_mem [lz3d_pkg::HistDepth];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  // Frame state.
  lz3d_pkg::phase_t phase_r, phase_nxt;
  lz3d_pkg::eng_t   eng_r, eng_nxt;
  logic [31:0]   pc_r, pc_nxt;
  logic [31:0]   exp_r, exp_nxt;
  logic [31:0]   shift_r, shift_nxt;
  logic [5:0]    left_r, left_nxt;
  logic [12:0]   pdist_r, pdist_nxt;

  // Copy engine state.
  logic [AW-1:0] src_r, src_nxt;
  logic [LW-1:0] remain_r, remain_nxt;
  logic          back1_r, back1_nxt;
  logic          first_r, first_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [7:0]    grp_r [NL];
  logic          grp_we;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    ob_r [NL];
  logic [7:0]    ob_nxt [NL];
  logic [3:0]    ocnt_r, ocnt_nxt;
  logic          olast_r, olast_nxt;
  logic [1:0]    oneed_r, oneed_nxt;
  logic [1:0]    ostat_r, ostat_nxt;

  // Combinational helpers.
  logic          out_free;
  logic          accept;
  logic          advance;
  logic          emit;
  logic [7:0]    cp_byte;
  logic          cp_go;
  logic [LW-1:0] cp_len;
  logic [12:0]   cp_back;
  logic [31:0]   room;
  logic [31:0]   pc_end;
  logic [5:0]    left_dec;
  lz3d_pkg::opcode_t op;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (eng_r != lz3d_pkg::ENG_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign op       = lz3d_pkg::opcode_t'(in_opcode);
  assign left_dec = (left_r != 6'd0) ? (left_r - 6'd1) : 6'd0;
  assign room     = exp_r - pc_r;
  assign pc_end   = pc_r + {{(32-LW){1'b0}}, cp_len};

  // Byte of the running copy; distance one reads the byte written just before.
  assign cp_byte = (back1_r && !first_r) ? prev_r : rd_data_r;
  assign emit    = (eng_r == lz3d_pkg::ENG_COPY) &&
                   ((cnt_r == 3'(NL - 1)) || (remain_r == LW'(1)));
  assign advance = (eng_r == lz3d_pkg::ENG_COPY) && (!emit || out_free);
  assign grp_we  = advance && !emit;

  // Copy request decode: link with a short length or an extended length byte.
  always_comb begin
    cp_go   = 1'b0;
    cp_len  = '0;
    cp_back = pdist_r;
    if (op == lz3d_pkg::OP_CHUNK && phase_r == lz3d_pkg::PH_EXT) begin
      cp_go   = 1'b1;
      cp_len  = LW'(in_chunk_byte) + LW'(lz3d_pkg::ExtLenBias);
      cp_back = pdist_r;
    end else if (op == lz3d_pkg::OP_LINK && phase_r == lz3d_pkg::PH_LINK &&
                 in_link_word[15:12] != 4'd0) begin
      cp_go   = 1'b1;
      cp_len  = LW'(in_link_word[15:12]) + LW'(lz3d_pkg::ShortBias);
      cp_back = {1'b0, in_link_word[11:0]} + 13'd1;
    end
  end

  // Next state, memory port and output beat.
  always_comb begin
    phase_nxt  = phase_r;
    eng_nxt    = eng_r;
    pc_nxt     = pc_r;
    exp_nxt    = exp_r;
    shift_nxt  = shift_r;
    left_nxt   = left_r;
    pdist_nxt  = pdist_r;
    src_nxt    = src_r;
    remain_nxt = remain_r;
    back1_nxt  = back1_r;
    first_nxt  = first_r;
    prev_nxt   = prev_r;
    cnt_nxt    = cnt_r;
    mem_we     = 1'b0;
    mem_wa     = pc_r[AW-1:0];
    mem_wd     = in_chunk_byte;
    rd_addr    = advance ? (src_r + AW'(1)) : src_r;

    out_valid_nxt = out_valid_r && out_stall;
    for (int i = 0; i < NL; i++) begin
      ob_nxt[i] = ob_r[i];
    end
    ocnt_nxt  = ocnt_r;
    olast_nxt = olast_r;
    oneed_nxt = oneed_r;
    ostat_nxt = ostat_r;

    if (accept) begin
      // Every accepted item starts from a one-beat result with no bytes.
      out_valid_nxt = 1'b1;
      for (int i = 0; i < NL; i++) begin
        ob_nxt[i] = 8'd0;
      end
      ocnt_nxt  = 4'd0;
      olast_nxt = 1'b1;
      ostat_nxt = lz3d_pkg::ST_OK;

      unique case (op)
        lz3d_pkg::OP_START: begin
          exp_nxt   = in_frame_length;
          pc_nxt    = 32'd0;
          shift_nxt = 32'd0;
          left_nxt  = 6'd0;
          pdist_nxt = 13'd0;
          phase_nxt = lz3d_pkg::choose_next(32'd0, in_frame_length, 6'd0, 32'd0);
        end
        lz3d_pkg::OP_FLAG: begin
          if (phase_r != lz3d_pkg::PH_FLAG) begin
            phase_nxt = lz3d_pkg::PH_IDLE;
            ostat_nxt = lz3d_pkg::ST_KIND;
          end else begin
            shift_nxt = in_flag_word;
            left_nxt  = 6'd32;
            phase_nxt = lz3d_pkg::choose_next(pc_r, exp_r, 6'd32, in_flag_word);
          end
        end
        default: begin
          if (op == lz3d_pkg::OP_CHUNK && phase_r == lz3d_pkg::PH_LIT) begin
            // Literal byte goes straight to history and out.
            mem_we    = 1'b1;
            pc_nxt    = pc_r + 32'd1;
            shift_nxt = shift_r << 1;
            left_nxt  = left_dec;
            phase_nxt = lz3d_pkg::choose_next(pc_r + 32'd1, exp_r, left_dec,
                                              shift_r << 1);
            ob_nxt[0] = in_chunk_byte;
            ocnt_nxt  = 4'd1;
          end else if (op == lz3d_pkg::OP_LINK && phase_r == lz3d_pkg::PH_LINK &&
                       in_link_word[15:12] == 4'd0) begin
            // Length comes in the next chunk byte.
            pdist_nxt = {1'b0, in_link_word[11:0]} + 13'd1;
            phase_nxt = lz3d_pkg::PH_EXT;
          end else if (cp_go) begin
            if ({19'd0, cp_back} > pc_r) begin
              phase_nxt = lz3d_pkg::PH_IDLE;
              ostat_nxt = lz3d_pkg::ST_BEFORE;
            end else if ({{(32-LW){1'b0}}, cp_len} > room) begin
              phase_nxt = lz3d_pkg::PH_IDLE;
              ostat_nxt = lz3d_pkg::ST_PAST;
            end else begin
              // Start the copy engine; its first read is issued now.
              out_valid_nxt = 1'b0;
              eng_nxt    = lz3d_pkg::ENG_COPY;
              rd_addr    = pc_r[AW-1:0] - cp_back[AW-1:0];
              src_nxt    = pc_r[AW-1:0] - cp_back[AW-1:0];
              remain_nxt = cp_len;
              back1_nxt  = (cp_back == 13'd1);
              first_nxt  = 1'b1;
              cnt_nxt    = 3'd0;
              shift_nxt  = shift_r << 1;
              left_nxt   = left_dec;
              phase_nxt  = lz3d_pkg::choose_next(pc_end, exp_r, left_dec,
                                                 shift_r << 1);
            end
          end else begin
            phase_nxt = lz3d_pkg::PH_IDLE;
            ostat_nxt = lz3d_pkg::ST_KIND;
          end
        end
      endcase
      oneed_nxt = lz3d_pkg::need_code(phase_nxt);
    end

    // Copy engine: one byte per cycle into the lane group, unless a stalled output holds a full group.
    if (advance) begin
      mem_we     = 1'b1;
      mem_wd     = cp_byte;
      pc_nxt     = pc_r + 32'd1;
      src_nxt    = src_r + AW'(1);
      remain_nxt = remain_r - LW'(1);
      first_nxt  = 1'b0;
      prev_nxt   = cp_byte;
      cnt_nxt    = cnt_r + 3'd1;
      if (emit) begin
        out_valid_nxt = 1'b1;
        for (int i = 0; i < NL; i++) begin
          if (3'(i) < cnt_r) begin
            ob_nxt[i] = grp_r[i];
          end else if (3'(i) == cnt_r) begin
            ob_nxt[i] = cp_byte;
          end else begin
            ob_nxt[i] = 8'd0;
          end
        end
        ocnt_nxt  = {1'b0, cnt_r} + 4'd1;
        olast_nxt = (remain_r == LW'(1));
        oneed_nxt = lz3d_pkg::need_code(phase_r);
        ostat_nxt = lz3d_pkg::ST_OK;
        cnt_nxt   = 3'd0;
        if (remain_r == LW'(1)) begin
          eng_nxt = lz3d_pkg::ENG_IDLE;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lz3d_pkg::PH_IDLE;
      eng_r       <= lz3d_pkg::ENG_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= 32'd0;
      exp_r       <= 32'd0;
      shift_r     <= 32'd0;
      left_r      <= 6'd0;
      pdist_r     <= 13'd0;
      remain_r    <= '0;
      cnt_r       <= 3'd0;
    end else begin
      phase_r     <= phase_nxt;
      eng_r       <= eng_nxt;
      out_valid_r <= out_valid_nxt;
      pc_r        <= pc_nxt;
      exp_r       <= exp_nxt;
      shift_r     <= shift_nxt;
      left_r      <= left_nxt;
      pdist_r     <= pdist_nxt;
      remain_r    <= remain_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    src_r   <= src_nxt;
    back1_r <= back1_nxt;
    first_r <= first_nxt;
    prev_r  <= prev_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
    oneed_r <= oneed_nxt;
    ostat_r <= ostat_nxt;
    for (int i = 0; i < NL; i++) begin
      ob_r[i] <= ob_nxt[i];
    end
    if (grp_we) begin
      grp_r[cnt_r] <= cp_byte;
    end
  end

  // History memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= hist_mem[rd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_byte_0      = ob_r[0];
  assign out_byte_1      = ob_r[1];
  assign out_byte_2      = ob_r[2];
  assign out_byte_3      = ob_r[3];
  assign out_byte_4      = ob_r[4];
  assign out_byte_5      = ob_r[5];
  assign out_byte_6      = ob_r[6];
  assign out_byte_7      = ob_r[7];
  assign out_byte_count  = ocnt_r;
  assign out_last_of_run = olast_r;
  assign out_next_need   = oneed_r;
  assign out_status      = ostat_r;

  // A beat never carries more bytes than there are lanes.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (ocnt_r <= 4'(NL)))
    else $error("byte count above lane count");

  // An error beat carries no bytes and ends the frame.
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ostat_r != lz3d_pkg::ST_OK) |->
      (ocnt_r == 4'd0 && oneed_r == lz3d_pkg::NEED_DONE && olast_r))
    else $error("error beat with bytes or open frame");

  // A running copy always has bytes left.
  a_copy_remain: assert property (@(posedge clk) disable iff (!rst_n)
    (eng_r == lz3d_pkg::ENG_COPY) |-> (remain_r != '0))
    else $error("copy engine running with nothing left");

  // The last byte of a copy closes the run and frees the engine.
  a_copy_end: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && remain_r == LW'(1)) |=>
      (eng_r == lz3d_pkg::ENG_IDLE && out_valid_r && olast_r))
    else $error("copy did not finish with a last beat");

endmodule

`default_nettype wire
